### design/sgd_pkg.sv
`timescale 1ns / 1ps
package sgd_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int EXP_SPAN        = 16;
	localparam int TBL_FRAC        = 30;
	localparam int TAYLOR_TERMS    = 20;
	localparam int TAYLOR_FRAC     = 56;

	localparam int TBL_W     = TBL_FRAC + 1;
	localparam int IDX_W     = $clog2(EXP_TABLE_DEPTH);
	localparam int EXP_T_W   = $clog2(EXP_SPAN) + FRAC_BITS;
	localparam int T_FRAC_W  = EXP_T_W - IDX_W;
	localparam int EXP_OUT_W = FRAC_BITS + 1;
	localparam int ONE       = 1 << FRAC_BITS;

	localparam int X_W      = 32;
	localparam int U_W      = 33;
	localparam int SLOPE_W  = 20;
	localparam int SHIFT_W  = 20;
	localparam int HEIGHT_W = 18;
	localparam int WIDTH_W  = 20;
	localparam int W2_W     = 24;
	localparam int AU_W     = 31;
	localparam int AUS_W    = 23;
	localparam int Z_W      = 39;
	localparam int S_W      = FRAC_BITS + 1;
	localparam int G_W      = HEIGHT_W;
	localparam int P_W      = 15;
	localparam int SP_W     = 19;
	localparam int SG_W     = 18;
	localparam int T1_W     = 21;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam int SIG_DEN_W = FRAC_BITS + 2;
	localparam int SIG_QUO_W = FRAC_BITS + 1;
	localparam int SIG_NUM_W = 2 * FRAC_BITS + 1;
	localparam int GAU_QUO_W = EXP_T_W;
	localparam int GAU_NUM_W = W2_W + GAU_QUO_W;
	localparam int DRV_QUO_W = 30;
	localparam int DRV_NUM_W = SG_W + AUS_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOPE        = 2'd0,
		REG_CENTRE_SHIFT = 2'd1,
		REG_BUMP_HEIGHT  = 2'd2,
		REG_BUMP_WIDTH   = 2'd3
	} cfg_reg_t;

	typedef logic [TBL_W-1:0] exp_tbl_t [EXP_TABLE_DEPTH+1];

	function automatic exp_tbl_t build_exp_tbl();
		exp_tbl_t tbl;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned ratio;
		longint unsigned prev;
		term = 64'd1 << TAYLOR_FRAC;
		sum  = term;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = (term * 64'(EXP_SPAN)) / 64'(EXP_TABLE_DEPTH * n);
			if ((n % 2) == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		ratio = (sum + (64'd1 << (TAYLOR_FRAC - TBL_FRAC - 1))) >> (TAYLOR_FRAC - TBL_FRAC);
		prev = 64'd1 << TBL_FRAC;
		tbl[0] = TBL_W'(prev);
		for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
			prev = (prev * ratio + (64'd1 << (TBL_FRAC - 1))) >> TBL_FRAC;
			tbl[k] = TBL_W'(prev);
		end
		return tbl;
	endfunction

	localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

### design/sgd_ifs.sv
`timescale 1ns / 1ps
interface sgd_sample_if import sgd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] x_value;
	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

interface sgd_result_if import sgd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] slope_out;
	logic                  saturated;
	modport source (output valid, output slope_out, output saturated, input ready);
	modport sink (input valid, input slope_out, input saturated, output ready);
endinterface

interface sgd_cfg_if import sgd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/sgd_neg_exp.sv
`timescale 1ns / 1ps
module sgd_neg_exp import sgd_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  logic [EXP_T_W-1:0]   t,
	input  logic                 zero,
	input  logic [TAG_W-1:0]     tag_in,
	output logic                 v_out,
	output logic [EXP_OUT_W-1:0] e,
	output logic [TAG_W-1:0]     tag_out
);

	localparam int PROD_W = TBL_W + FRAC_BITS;
	localparam int RND_SH = TBL_FRAC - FRAC_BITS;

	logic [IDX_W-1:0]     idx;
	logic [IDX_W:0]       idx_nx;
	logic [FRAC_BITS-1:0] frac;
	logic [TBL_W-1:0]     diff;
	logic [PROD_W-1:0]    prod;
	logic [TBL_W:0]       rnd;

	logic                 v_s1, v_s2;
	logic [TBL_W-1:0]     e0_s1, e1_s1, mant_s2;
	logic [FRAC_BITS-1:0] frac_s1;
	logic                 zero_s1, zero_s2;
	logic [TAG_W-1:0]     tag_s1, tag_s2;

	assign idx    = t[EXP_T_W-1 -: IDX_W];
	assign idx_nx = {1'b0, idx} + (IDX_W+1)'(1);
	assign frac   = FRAC_BITS'(t[T_FRAC_W-1:0]) << (FRAC_BITS - T_FRAC_W);

	assign diff = e0_s1 - e1_s1;
	assign prod = PROD_W'(diff) * PROD_W'(frac_s1);
	assign rnd  = {1'b0, mant_s2} + (TBL_W+1)'(1 << (RND_SH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s1   <= EXP_TBL[idx];
			e1_s1   <= EXP_TBL[idx_nx];
			frac_s1 <= frac;
			zero_s1 <= zero;
			tag_s1  <= tag_in;
			mant_s2 <= e0_s1 - prod[PROD_W-1:FRAC_BITS];
			zero_s2 <= zero_s1;
			tag_s2  <= tag_s1;
		end
	end

	assign v_out   = v_s2;
	assign e       = zero_s2 ? '0 : EXP_OUT_W'(rnd >> RND_SH);
	assign tag_out = tag_s2;

endmodule

### design/sgd_div.sv
`timescale 1ns / 1ps
module sgd_div import sgd_pkg::*; #(
	parameter int NUM_W = SIG_NUM_W,
	parameter int DEN_W = SIG_DEN_W,
	parameter int QUO_W = SIG_QUO_W,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             v_out,
	output logic [QUO_W-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);

	// One quotient bit per stage; the quotient bits shift in behind the numerator bits.
	logic             v_q   [QUO_W];
	logic [DEN_W-1:0] rem_q [QUO_W];
	logic [QUO_W-1:0] nq_q  [QUO_W];
	logic [DEN_W-1:0] den_q [QUO_W];
	logic [TAG_W-1:0] tag_q [QUO_W];

	logic             v_nx   [QUO_W];
	logic [DEN_W-1:0] rem_nx [QUO_W];
	logic [QUO_W-1:0] nq_nx  [QUO_W];
	logic [DEN_W-1:0] den_nx [QUO_W];
	logic [TAG_W-1:0] tag_nx [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic             v_i;
		logic [DEN_W-1:0] rem_i;
		logic [QUO_W-1:0] nq_i;
		logic [DEN_W-1:0] den_i;
		logic [TAG_W-1:0] tag_i;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_head
			assign v_i   = v_in;
			assign rem_i = DEN_W'(num >> QUO_W);
			assign nq_i  = num[QUO_W-1:0];
			assign den_i = den;
			assign tag_i = tag_in;
		end else begin : g_body
			assign v_i   = v_q[i-1];
			assign rem_i = rem_q[i-1];
			assign nq_i  = nq_q[i-1];
			assign den_i = den_q[i-1];
			assign tag_i = tag_q[i-1];
		end

		assign trial     = {rem_i, nq_i[QUO_W-1]};
		assign ge        = trial >= {1'b0, den_i};
		assign v_nx[i]   = v_i;
		assign rem_nx[i] = ge ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
		assign nq_nx[i]  = {nq_i[QUO_W-2:0], ge};
		assign den_nx[i] = den_i;
		assign tag_nx[i] = tag_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUO_W; i++)
				v_q[i] <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < QUO_W; i++)
				v_q[i] <= v_nx[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QUO_W; i++) begin
				rem_q[i] <= rem_nx[i];
				nq_q[i]  <= nq_nx[i];
				den_q[i] <= den_nx[i];
				tag_q[i] <= tag_nx[i];
			end
		end
	end

	assign v_out   = v_q[QUO_W-1];
	assign quo     = nq_q[QUO_W-1];
	assign tag_out = tag_q[QUO_W-1];

endmodule

### design/sigmoid_gaussian_derivative_unit.sv
`timescale 1ns / 1ps
// Channel   Modport  Transaction
// -------   -------  ------------------------------------------------
// sample    sink     one x_value in, signed Q16.16
// result    source   one slope_out and saturated flag per sample
// cfg       sink     one register write: index and data, always ready
//
// One sample is taken every cycle unless halted; each passes two
// table-interpolation exp units and three bit-per-stage dividers; the
// sigmoid and Gaussian paths run in parallel. Reset clears all valid
// bits and sets the registers to their defaults. The whole pipeline
// advances together and halts only while the skid register beside the
// output register holds a result; sample.ready is low, so none is lost.
module sigmoid_gaussian_derivative_unit import sgd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sgd_sample_if.sink   sample,
	sgd_result_if.source result,
	sgd_cfg_if.sink      cfg
);

	localparam int GAU_TAG_W = 1 + AUS_W + 1;
	localparam int EXP_TAG_W = AUS_W + 1;
	localparam int DRV_TAG_W = T1_W + 1;

	logic [SLOPE_W-1:0]         slope_q;
	logic signed [SHIFT_W-1:0]  centre_shift_q;
	logic [HEIGHT_W-1:0]        bump_height_q;
	logic [WIDTH_W-1:0]         bump_width_q;
	logic [W2_W-1:0]            w2_q;
	logic [2*WIDTH_W-1:0]       wsq;
	logic [W2_W-1:0]            w2_nx;

	logic                       en;

	logic                       v_s1, v_s2, v_s3, v_s4;
	logic signed [U_W-1:0]      u_s1;
	logic [U_W-1:0]             u_mag;
	logic signed [37:0]         zhi_s2;
	logic [SLOPE_W-1:0]         zlo_s2;
	logic [AU_W-1:0]            au_s2;
	logic                       uneg_s2, uneg_s3, uneg_s4;
	logic signed [Z_W-1:0]      z_s3;
	logic [2*AU_W-1:0]          aa_s3;
	logic [AUS_W-1:0]           au_s3, au_s4;
	logic [Z_W-1:0]             z_mag;
	logic                       gbig;
	logic                       gbig_s4;
	logic [GAU_NUM_W-1:0]       gnum_s4;

	logic                       e1_v;
	logic [EXP_OUT_W-1:0]       e1;
	logic                       e1_zneg;
	logic [SIG_DEN_W-1:0]       sig_den;
	logic [SIG_NUM_W-1:0]       sig_num;
	logic                       d1_v;
	logic [SIG_QUO_W-1:0]       d1_quo;
	logic                       d1_zneg;

	logic                       d2_v;
	logic [GAU_QUO_W-1:0]       d2_quo;
	logic [GAU_TAG_W-1:0]       d2_tag;
	logic                       e2_v;
	logic [EXP_OUT_W-1:0]       e2;
	logic [EXP_TAG_W-1:0]       e2_tag;

	logic                       v_s23, v_s24, v_s25, v_s26, v_s27;
	logic [S_W-1:0]             s_s23, s_s24, s_s25, s_s26, s_s27;
	logic                       gv_s27;
	logic [G_W-1:0]             g_s27, g_s28, g_s29;
	logic [AUS_W-1:0]           au_s27, au_s28;
	logic                       uneg_s27, uneg_s28, uneg_s29, uneg_s30;
	logic                       v_s28, v_s29, v_s30;
	logic [P_W-1:0]             p_s28;
	logic [SG_W-1:0]            sg_s28;
	logic [SP_W-1:0]            sp_s29;
	logic [DRV_NUM_W-1:0]       dnum_s29, dnum_s30;
	logic [T1_W-1:0]            t1_s30;

	logic                       d3_v;
	logic [DRV_QUO_W-1:0]       d3_quo;
	logic [DRV_TAG_W-1:0]       d3_tag;
	logic signed [X_W:0]        t2;
	logic signed [X_W:0]        total;
	logic                       sat;
	logic [X_W-1:0]             res_val;

	logic                       out_v_q, skid_v_q;
	logic [X_W-1:0]             out_val_q, skid_val_q;
	logic                       out_sat_q, skid_sat_q;
	logic                       push, pop;

	// Configuration registers.
	assign cfg.ready = 1'b1;
	assign wsq       = (2*WIDTH_W)'(bump_width_q) * (2*WIDTH_W)'(bump_width_q);
	assign w2_nx     = (wsq[2*WIDTH_W-1:FRAC_BITS] == '0) ? W2_W'(1) :
	                   wsq[2*WIDTH_W-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q        <= SLOPE_W'(ONE);
			centre_shift_q <= '0;
			bump_height_q  <= HEIGHT_W'(ONE);
			bump_width_q   <= WIDTH_W'(ONE);
			w2_q           <= W2_W'(ONE);
		end else begin
			w2_q <= w2_nx;
			if (cfg.valid) begin
				case (cfg_reg_t'(cfg.index))
					REG_SLOPE:        slope_q        <= cfg.data[SLOPE_W-1:0];
					REG_CENTRE_SHIFT: centre_shift_q <= $signed(cfg.data[SHIFT_W-1:0]);
					REG_BUMP_HEIGHT:  bump_height_q  <= cfg.data[HEIGHT_W-1:0];
					REG_BUMP_WIDTH:   bump_width_q   <= cfg.data[WIDTH_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign en           = !skid_v_q;
	assign sample.ready = en;

	// Front stages: offset, partial products of slope*u and their sum, square of |u|.
	assign u_mag = u_s1[U_W-1] ? U_W'(-u_s1) : U_W'(u_s1);
	assign z_mag = z_s3[Z_W-1] ? Z_W'(-z_s3) : Z_W'(z_s3);
	assign gbig  = aa_s3[2*AU_W-1:GAU_QUO_W] >= (2*AU_W-GAU_QUO_W)'(w2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= U_W'(sample.x_value) - U_W'(centre_shift_q);
			zhi_s2  <= $signed({1'b0, slope_q}) * $signed(u_s1[U_W-1:FRAC_BITS]);
			zlo_s2  <= SLOPE_W'(((SLOPE_W+FRAC_BITS)'(slope_q) *
			           (SLOPE_W+FRAC_BITS)'(u_s1[FRAC_BITS-1:0])) >> FRAC_BITS);
			au_s2   <= (|u_mag[U_W-1:AU_W]) ? {AU_W{1'b1}} : u_mag[AU_W-1:0];
			uneg_s2 <= u_s1[U_W-1];
			z_s3    <= Z_W'(zhi_s2) + Z_W'($signed({1'b0, zlo_s2}));
			aa_s3   <= (2*AU_W)'(au_s2) * (2*AU_W)'(au_s2);
			au_s3   <= au_s2[AUS_W-1:0];
			uneg_s3 <= uneg_s2;
			gbig_s4 <= gbig;
			gnum_s4 <= gbig ? '0 : aa_s3[GAU_NUM_W-1:0];
			au_s4   <= au_s3;
			uneg_s4 <= uneg_s3;
		end
	end

	// Sigmoid path.
	sgd_neg_exp #(
		.TAG_W (1)
	) u_sig_exp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_s3),
		.t       (z_mag[EXP_T_W-1:0]),
		.zero    (|z_mag[Z_W-1:EXP_T_W]),
		.tag_in  (z_s3[Z_W-1]),
		.v_out   (e1_v),
		.e       (e1),
		.tag_out (e1_zneg)
	);

	assign sig_den = SIG_DEN_W'(ONE) + SIG_DEN_W'(e1);
	assign sig_num = {1'b1, {(SIG_NUM_W-1){1'b0}}} + SIG_NUM_W'(sig_den >> 1);

	sgd_div #(
		.NUM_W (SIG_NUM_W),
		.DEN_W (SIG_DEN_W),
		.QUO_W (SIG_QUO_W),
		.TAG_W (1)
	) u_sig_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (e1_v),
		.num     (sig_num),
		.den     (sig_den),
		.tag_in  (e1_zneg),
		.v_out   (d1_v),
		.quo     (d1_quo),
		.tag_out (d1_zneg)
	);

	// Gaussian path.
	sgd_div #(
		.NUM_W (GAU_NUM_W),
		.DEN_W (W2_W),
		.QUO_W (GAU_QUO_W),
		.TAG_W (GAU_TAG_W)
	) u_gau_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_s4),
		.num     (gnum_s4),
		.den     (w2_q),
		.tag_in  ({gbig_s4, au_s4, uneg_s4}),
		.v_out   (d2_v),
		.quo     (d2_quo),
		.tag_out (d2_tag)
	);

	sgd_neg_exp #(
		.TAG_W (EXP_TAG_W)
	) u_gau_exp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (d2_v),
		.t       (d2_quo),
		.zero    (d2_tag[GAU_TAG_W-1]),
		.tag_in  (d2_tag[EXP_TAG_W-1:0]),
		.v_out   (e2_v),
		.e       (e2),
		.tag_out (e2_tag)
	);

	// Products of the two paths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s23  <= 1'b0;
			v_s24  <= 1'b0;
			v_s25  <= 1'b0;
			v_s26  <= 1'b0;
			v_s27  <= 1'b0;
			gv_s27 <= 1'b0;
			v_s28  <= 1'b0;
			v_s29  <= 1'b0;
			v_s30  <= 1'b0;
		end else if (en) begin
			v_s23  <= d1_v;
			v_s24  <= v_s23;
			v_s25  <= v_s24;
			v_s26  <= v_s25;
			v_s27  <= v_s26;
			gv_s27 <= e2_v;
			v_s28  <= v_s27 && gv_s27;
			v_s29  <= v_s28;
			v_s30  <= v_s29;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s23    <= d1_zneg ? S_W'(ONE) - d1_quo : d1_quo;
			s_s24    <= s_s23;
			s_s25    <= s_s24;
			s_s26    <= s_s25;
			s_s27    <= s_s26;
			g_s27    <= G_W'(((HEIGHT_W+EXP_OUT_W)'(bump_height_q) *
			            (HEIGHT_W+EXP_OUT_W)'(e2)) >> FRAC_BITS);
			au_s27   <= e2_tag[EXP_TAG_W-1:1];
			uneg_s27 <= e2_tag[0];
			p_s28    <= P_W'(((2*S_W)'(s_s27) * (2*S_W)'(S_W'(ONE) - s_s27)) >> FRAC_BITS);
			sg_s28   <= SG_W'(((S_W+G_W)'(s_s27) * (S_W+G_W)'(g_s27)) >> FRAC_BITS);
			g_s28    <= g_s27;
			au_s28   <= au_s27;
			uneg_s28 <= uneg_s27;
			sp_s29   <= SP_W'(((SLOPE_W+P_W)'(slope_q) * (SLOPE_W+P_W)'(p_s28)) >> FRAC_BITS);
			dnum_s29 <= DRV_NUM_W'(sg_s28) * DRV_NUM_W'({au_s28, 1'b0});
			g_s29    <= g_s28;
			uneg_s29 <= uneg_s28;
			t1_s30   <= T1_W'(((SP_W+G_W)'(sp_s29) * (SP_W+G_W)'(g_s29)) >> FRAC_BITS);
			dnum_s30 <= dnum_s29;
			uneg_s30 <= uneg_s29;
		end
	end

	sgd_div #(
		.NUM_W (DRV_NUM_W),
		.DEN_W (W2_W),
		.QUO_W (DRV_QUO_W),
		.TAG_W (DRV_TAG_W)
	) u_drv_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_s30),
		.num     (dnum_s30),
		.den     (w2_q),
		.tag_in  ({t1_s30, uneg_s30}),
		.v_out   (d3_v),
		.quo     (d3_quo),
		.tag_out (d3_tag)
	);

	// Sum and saturation.
	assign t2      = d3_tag[0] ? $signed((X_W+1)'(d3_quo)) : -$signed((X_W+1)'(d3_quo));
	assign total   = $signed((X_W+1)'(d3_tag[DRV_TAG_W-1:1])) + t2;
	assign sat     = total[X_W] != total[X_W-1];
	assign res_val = !sat ? total[X_W-1:0] :
	                 (total[X_W] ? {1'b1, {(X_W-1){1'b0}}} : {1'b0, {(X_W-1){1'b1}}});

	// Output register with a skid register beside it.
	assign push = en && d3_v;
	assign pop  = out_v_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop)
				skid_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q || pop)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_val_q <= skid_val_q;
				out_sat_q <= skid_sat_q;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_val_q <= res_val;
				out_sat_q <= sat;
			end else begin
				skid_val_q <= res_val;
				skid_sat_q <= sat;
			end
		end
	end

	assign result.valid     = out_v_q;
	assign result.slope_out = $signed(out_val_q);
	assign result.saturated = out_sat_q;

endmodule

### bench/tb_sigmoid_gaussian_derivative_unit.sv
`timescale 1ns / 1ps
module tb_sigmoid_gaussian_derivative_unit;
	import sgd_pkg::*;

	localparam int PIPE_LAT = 61;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic signed [31:0] value;
		logic               sat;
	} deriv_t;

	logic clk;
	logic arst_n;

	sgd_sample_if sample ();
	sgd_result_if result ();
	sgd_cfg_if    cfg ();

	sigmoid_gaussian_derivative_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	longint unsigned exp_lut [EXP_TABLE_DEPTH+1];
	longint unsigned cur_slope;
	longint          cur_shift;
	longint unsigned cur_height;
	longint unsigned cur_width;

	deriv_t expected_q [$];
	int     send_idle_pct;
	int     recv_idle_pct;
	int     quiet_cycles = 0;
	bit     failed = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void fill_exp_lut();
		longint unsigned term;
		longint unsigned acc;
		longint unsigned ratio;
		term = 64'd1 << 56;
		acc  = term;
		for (int n = 1; n <= 20; n++) begin
			term = (term * 64'd16) / (64'd256 * n);
			if (n % 2 == 1)
				acc -= term;
			else
				acc += term;
		end
		ratio = (acc + (64'd1 << 25)) >> 26;
		exp_lut[0] = 64'd1 << 30;
		for (int k = 1; k <= EXP_TABLE_DEPTH; k++)
			exp_lut[k] = (exp_lut[k-1] * ratio + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint unsigned decay(longint unsigned t);
		longint unsigned pos;
		longint unsigned idx;
		longint unsigned frac;
		longint unsigned v;
		if (t >= (64'd16 << 16))
			return 0;
		pos  = (t * 256) / 16;
		idx  = pos >> 16;
		frac = pos & 64'hFFFF;
		if (idx >= 256)
			return 0;
		v = exp_lut[idx] - (((exp_lut[idx] - exp_lut[idx+1]) * frac) >> 16);
		return (v + (64'd1 << 13)) >> 14;
	endfunction

	function automatic deriv_t predict_derivative(logic signed [31:0] x);
		longint unsigned unity;
		longint          u;
		longint          z;
		longint          t2;
		longint          total;
		longint unsigned mag;
		longint unsigned e;
		longint unsigned s;
		longint unsigned w2;
		longint unsigned au;
		longint unsigned q;
		longint unsigned g;
		longint unsigned p;
		longint unsigned t1;
		longint unsigned sg;
		longint unsigned num;
		deriv_t r;
		unity = 64'd65536;
		u     = longint'(x) - cur_shift;
		z     = (longint'(cur_slope) * u) >>> 16;
		mag   = (z < 0) ? -z : z;
		e     = decay(mag);
		s     = (unity * unity + ((unity + e) >> 1)) / (unity + e);
		if (z < 0)
			s = unity - s;
		w2 = (cur_width * cur_width) >> 16;
		if (w2 == 0)
			w2 = 1;
		au = (u < 0) ? -u : u;
		num = au;
		if (au > 64'h7FFFFFFF)
			au = 64'h7FFFFFFF;
		q  = (au * au) / w2;
		g  = (cur_height * decay(q)) >> 16;
		p  = (s * (unity - s)) >> 16;
		t1 = (((cur_slope * p) >> 16) * g) >> 16;
		sg = (s * g) >> 16;
		num = (sg * 2 * num) / w2;
		t2 = (u < 0) ? longint'(num) : -longint'(num);
		total = longint'(t1) + t2;
		r.sat = 1'b0;
		if (total > 64'sd2147483647) begin
			total = 64'sd2147483647;
			r.sat = 1'b1;
		end else if (total < -64'sd2147483648) begin
			total = -64'sd2147483648;
			r.sat = 1'b1;
		end
		r.value = total[31:0];
		return r;
	endfunction

	task automatic send_sample(logic signed [31:0] x);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid   <= 1'b1;
		sample.x_value <= x;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
		expected_q.push_back(predict_derivative(x));
	endtask

	task automatic write_register(cfg_reg_t idx, logic [19:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			REG_SLOPE:        cur_slope = data;
			REG_CENTRE_SHIFT: cur_shift = longint'($signed(data));
			REG_BUMP_HEIGHT:  cur_height = data[17:0];
			REG_BUMP_WIDTH:   cur_width = data;
			default: ;
		endcase
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	task automatic configure(logic [19:0] sl, logic [19:0] sh, logic [19:0] ht,
			logic [19:0] wd);
		drain();
		write_register(REG_SLOPE, sl);
		write_register(REG_CENTRE_SHIFT, sh);
		write_register(REG_BUMP_HEIGHT, ht);
		write_register(REG_BUMP_WIDTH, wd);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] near_sample(int spread);
		return 32'($signed(cur_shift) + $signed($urandom_range(2 * spread, 0)) - spread);
	endfunction

	task automatic test_extremes();
		logic signed [31:0] edges [$];
		edges = '{32'sh7FFFFFFF, 32'sh80000000, 0, 1, -1, 32'sh10000, -32'sh10000,
			32'sh55555555, 32'shAAAAAAAA, 32'sh00100000, -32'sh00100000,
			32'sh00008000, -32'sh00008000, 32'sh00030000, -32'sh00030000};
		foreach (edges[i])
			send_sample(edges[i]);
	endtask

	task automatic test_register_extremes();
		configure(20'd655360, 20'hB0000, 20'd131072, 20'd6554);
		for (int i = 0; i < 4; i++)
			send_sample(near_sample(65536));
		configure(20'd6554, 20'h50000, 20'd655, 20'd655360);
		for (int i = 0; i < 3; i++)
			send_sample(near_sample(655360));
		configure(20'hFFFFF, 20'h80000, 20'h3FFFF, 20'd0);
		send_sample(0);
		send_sample(near_sample(4));
		send_sample(32'sh7FFFFFFF);
	endtask

	task automatic test_random(int count);
		logic signed [31:0] x;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9, 0))
				0:       x = $urandom();
				1:       x = near_sample(1 << 22);
				default: x = near_sample(int'(cur_width) * 4 + 65536);
			endcase
			send_sample(x);
		end
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 9; phase++) begin
			if (phase == 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 27;
			end else if (phase == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			configure(20'($urandom_range(655360, 6554)),
				20'($urandom_range(327680, 0) - $urandom_range(327680, 0)),
				20'($urandom_range(131072, 655)),
				20'($urandom_range(655360, 6554)));
			test_random(75);
		end
	endtask

	always @(posedge clk) begin
		deriv_t want;
		if (result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction: slope_out %0d", result.slope_out);
				failed = 1'b1;
			end else begin
				want = expected_q.pop_front();
				if (result.slope_out !== want.value) begin
					$error("slope_out: expected %0d, actual %0d", want.value,
						result.slope_out);
					failed = 1'b1;
				end
				if (result.saturated !== want.sat) begin
					$error("saturated: expected %0d, actual %0d", want.sat,
						result.saturated);
					failed = 1'b1;
				end
			end
		end
		result.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("FAIL sigmoid_gaussian_derivative_unit");
			$finish;
		end
	end

	initial begin
		send_idle_pct  = 27;
		recv_idle_pct  = 52;
		arst_n         = 1'b0;
		sample.valid   = 1'b0;
		sample.x_value = '0;
		cfg.valid      = 1'b0;
		cfg.index      = REG_SLOPE;
		cfg.data       = '0;
		cur_slope      = 65536;
		cur_shift      = 0;
		cur_height     = 65536;
		cur_width      = 65536;
		fill_exp_lut();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_register_extremes();
		test_random_settings();
		drain();
		if (!failed)
			$display("PASS sigmoid_gaussian_derivative_unit");
		else
			$display("FAIL sigmoid_gaussian_derivative_unit");
		$finish;
	end
endmodule

### sim.f
design/sgd_pkg.sv
design/sgd_ifs.sv
design/sgd_neg_exp.sv
design/sgd_div.sv
design/sigmoid_gaussian_derivative_unit.sv
bench/tb_sigmoid_gaussian_derivative_unit.sv
